/* src/blr_pkg.sv */
// shared types for the bresenham line rasterizer
package blr_pkg;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_DRAW  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

/* src/blr_ctrl.sv */
// controller state machine for the bresenham line rasterizer
module blr_ctrl
    import blr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_DRAW;
            end
            S_DRAW: begin
                if (i_out_ready && i_status.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DRAW);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.setup = (r_state == S_SETUP);
    assign o_cmd.step  = (r_state == S_DRAW) && i_out_ready && !i_status.last;

    // input and output sides are never open at once
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a pixel is pending");

    // the first pixel follows the setup cycle
    a_setup_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.setup |=> o_out_valid)
        else $error("no pixel after setup");

    // taking the last pixel frees the input
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_status.last) |=> o_in_ready)
        else $error("block not idle after last pixel");

    // a new request always goes through setup
    a_load_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (o_cmd.setup && !o_out_valid))
        else $error("request accepted without setup");

endmodule

/* src/blr_datapath.sv */
// position, error term and step counter datapath for the line rasterizer
module blr_datapath
    import blr_pkg::*;
#(
    parameter int COORD_WIDTH = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic signed [COORD_WIDTH-1:0] o_pixel_x,
    output logic signed [COORD_WIDTH-1:0] o_pixel_y,
    output t_status                       o_status
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = COORD_WIDTH + 2;

    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [CW-1:0] r_ex;
    logic [CW-1:0] r_ey;
    logic [EW-1:0] r_err;
    logic [EW-1:0] r_inc_diag;
    logic [EW-1:0] r_inc_straight;
    logic [CW-1:0] r_steps;
    logic          r_sx_neg;
    logic          r_sy_neg;
    logic          r_x_major;

    logic [CW:0]   w_dx;
    logic [CW:0]   w_dy;
    logic [CW:0]   w_dx_neg;
    logic [CW:0]   w_dy_neg;
    logic [CW-1:0] w_adx;
    logic [CW-1:0] w_ady;
    logic          w_x_major;
    logic [CW-1:0] w_major;
    logic [CW-1:0] w_minor;
    logic [EW-1:0] w_minor2;
    logic [EW-1:0] w_major2;
    logic          w_diag;
    logic          w_step_x;
    logic          w_step_y;
    logic [CW-1:0] w_x_inc;
    logic [CW-1:0] w_y_inc;

    assign w_dx      = {r_ex[CW-1], r_ex} - {r_x[CW-1], r_x};
    assign w_dy      = {r_ey[CW-1], r_ey} - {r_y[CW-1], r_y};
    assign w_dx_neg  = -w_dx;
    assign w_dy_neg  = -w_dy;
    assign w_adx     = w_dx[CW] ? w_dx_neg[CW-1:0] : w_dx[CW-1:0];
    assign w_ady     = w_dy[CW] ? w_dy_neg[CW-1:0] : w_dy[CW-1:0];
    assign w_x_major = (w_adx > w_ady);
    assign w_major   = w_x_major ? w_adx : w_ady;
    assign w_minor   = w_x_major ? w_ady : w_adx;
    assign w_minor2  = {1'b0, w_minor, 1'b0};
    assign w_major2  = {1'b0, w_major, 1'b0};

    // minor axis moves when the error term is not negative
    assign w_diag   = !r_err[EW-1];
    assign w_step_x = r_x_major || w_diag;
    assign w_step_y = !r_x_major || w_diag;
    assign w_x_inc  = r_sx_neg ? {CW{1'b1}} : {{(CW-1){1'b0}}, 1'b1};
    assign w_y_inc  = r_sy_neg ? {CW{1'b1}} : {{(CW-1){1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_start_x;
            r_y  <= i_start_y;
            r_ex <= i_end_x;
            r_ey <= i_end_y;
        end else if (i_cmd.setup) begin
            r_sx_neg       <= w_dx[CW];
            r_sy_neg       <= w_dy[CW];
            r_x_major      <= w_x_major;
            r_steps        <= w_major;
            r_err          <= w_minor2 - {2'b00, w_major};
            r_inc_diag     <= w_minor2 - w_major2;
            r_inc_straight <= w_minor2;
        end else if (i_cmd.step) begin
            if (w_step_x) begin
                r_x <= r_x + w_x_inc;
            end
            if (w_step_y) begin
                r_y <= r_y + w_y_inc;
            end
            r_err   <= r_err + (w_diag ? r_inc_diag : r_inc_straight);
            r_steps <= r_steps - 1'b1;
        end
    end

    assign o_pixel_x     = r_x;
    assign o_pixel_y     = r_y;
    assign o_status.last = (r_steps == '0);

    // each step consumes exactly one major-axis count
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_steps == $past(r_steps) - 1'b1))
        else $error("step counter out of sequence");

endmodule

/* src/bresenham_line_rasterizer.sv */
// top level: bresenham line rasterizer, one segment in, one pixel per request out
// the first pixel is valid once setup is done and the controller enters draw
// 1 + max(|dx|, |dy|) pixels per segment: the start and one per major-axis step
// a new segment is accepted only after the last pixel of the one before is taken
// reset: synchronous active-low i_rst_n returns the controller to idle, ready for a segment
// no clearing pass; position and error registers are loaded by each segment
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_WIDTH = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_pixel_x,
    output logic signed [COORD_WIDTH-1:0] o_pixel_y,
    output logic                          o_last_pixel
);

    t_cmd    w_cmd;
    t_status w_status;

    blr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    blr_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_status  (w_status)
    );

    assign o_last_pixel = w_status.last;

endmodule

/* sim/tb_bresenham_line_rasterizer.sv */
`timescale 1ns / 100ps
// testbench for the bresenham line rasterizer: segments in, traced pixel stream checked in order
module tb_bresenham_line_rasterizer;

    localparam int CW              = 6;
    localparam int RANDOM_SEGMENTS = 130;
    localparam int STEADY_TAIL     = 30;
    localparam int QUIET_LIMIT     = 200;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 30;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    class t_line_scoreboard;
        t_pixel pending_pixels[$];
        t_coord pos_x;
        t_coord pos_y;
        int     err_term;
        int     errors;

        function new();
            pos_x    = '0;
            pos_y    = '0;
            err_term = 0;
            errors   = 0;
        endfunction

        function void report(string what, int want, int got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        // walk the segment with integer error terms and queue every pixel
        function void trace_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
            int     dx;
            int     dy;
            int     step_x;
            int     step_y;
            int     major;
            int     minor;
            int     k;
            bit     x_major;
            t_pixel pix;
            dx     = int'(ex) - int'(sx);
            dy     = int'(ey) - int'(sy);
            step_x = 1;
            step_y = 1;
            if (dx < 0) begin
                dx     = -dx;
                step_x = -1;
            end
            if (dy < 0) begin
                dy     = -dy;
                step_y = -1;
            end
            x_major  = dx > dy;
            major    = x_major ? dx : dy;
            minor    = x_major ? dy : dx;
            err_term = 2 * minor - major;
            pos_x    = sx;
            pos_y    = sy;
            pix.x    = pos_x;
            pix.y    = pos_y;
            pix.last = (major == 0);
            pending_pixels.push_back(pix);
            for (k = 0; k < major; k++) begin
                if (err_term >= 0) begin
                    if (x_major) pos_y = t_coord'(int'(pos_y) + step_y);
                    else         pos_x = t_coord'(int'(pos_x) + step_x);
                    err_term += 2 * (minor - major);
                end else begin
                    err_term += 2 * minor;
                end
                if (x_major) pos_x = t_coord'(int'(pos_x) + step_x);
                else         pos_y = t_coord'(int'(pos_y) + step_y);
                pix.x    = pos_x;
                pix.y    = pos_y;
                pix.last = (k == major - 1);
                pending_pixels.push_back(pix);
            end
        endfunction

        function void check_pixel(t_coord x, t_coord y, logic last);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d last=%0b",
                             $time, x, y, last);
                end
                return;
            end
            want = pending_pixels.pop_front();
            if (x !== want.x)       report("pixel_x", $signed(want.x), x);
            if (y !== want.y)       report("pixel_y", $signed(want.y), y);
            if (last !== want.last) report("last_pixel", want.last, last);
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_coord i_start_x;
    t_coord i_start_y;
    t_coord i_end_x;
    t_coord i_end_y;
    logic   o_valid;
    logic   i_ready;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic   o_last_pixel;

    t_line_scoreboard sb;
    bit steady = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    bresenham_line_rasterizer #(
        .COORD_WIDTH(CW)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_coord rand_coord();
        return t_coord'($urandom_range(0, 63));
    endfunction

    // move by d, or by -d when that would leave the coordinate range
    function automatic t_coord offset_coord(t_coord c, int d);
        int v;
        v = int'(c) + d;
        if (v > 31 || v < -32) v = int'(c) - d;
        return t_coord'(v);
    endfunction

    task automatic send_segment(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        int gap;
        if (!steady && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.trace_segment(sx, sy, ex, ey);
    endtask

    // pixel receiver with random stall bursts
    always @(posedge i_clk) begin
        if (o_valid && i_ready) sb.check_pixel(o_pixel_x, o_pixel_y, o_last_pixel);
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int     n;
        int     mode;
        int     d;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        sb = new();
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_start_x <= '0;
        i_start_y <= '0;
        i_end_x   <= '0;
        i_end_y   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length
        send_segment(0, 0, 0, 0);
        send_segment(-32, -32, -32, -32);
        send_segment(31, 31, 31, 31);
        // diagonals, full-range and short, y major on ties
        send_segment(-32, -32, 31, 31);
        send_segment(31, -32, -32, 31);
        send_segment(0, 0, 3, -3);
        // axis-aligned extremes
        send_segment(-32, 0, 31, 0);
        send_segment(0, -32, 0, 31);
        send_segment(31, 5, -32, 5);
        send_segment(5, 31, 5, -32);
        // nearly flat and nearly steep
        send_segment(-32, -32, 31, -31);
        send_segment(-32, -32, -31, 31);
        // all octants
        send_segment(0, 0, 5, 2);
        send_segment(0, 0, -5, 2);
        send_segment(0, 0, 5, -2);
        send_segment(0, 0, -5, -2);
        send_segment(0, 0, 2, 5);
        send_segment(0, 0, -2, 5);
        send_segment(0, 0, 2, -5);
        send_segment(0, 0, -2, -5);

        for (n = 0; n < RANDOM_SEGMENTS; n++) begin
            if (n == RANDOM_SEGMENTS - STEADY_TAIL) steady = 1'b1;
            mode = $urandom_range(0, 9);
            sx   = rand_coord();
            sy   = rand_coord();
            if (mode < 5) begin
                ex = rand_coord();
                ey = rand_coord();
            end else if (mode < 8) begin
                ex = offset_coord(sx, int'($urandom_range(0, 8)) - 4);
                ey = offset_coord(sy, int'($urandom_range(0, 8)) - 4);
            end else if (mode == 8) begin
                ex = sx;
                ey = sy;
            end else begin
                d  = $urandom_range(0, 31);
                ex = offset_coord(sx, $urandom_range(0, 1) ? d : -d);
                ey = offset_coord(sy, $urandom_range(0, 1) ? d : -d);
            end
            send_segment(sx, sy, ex, ey);
        end
        i_valid <= 1'b0;

        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
